// ===== hw/rtl/ssu_pkg.sv =====
// Shared types and constants for the sorted set union table.
package ssu_pkg;

  localparam int unsigned DefaultDepth = 32;
  localparam int unsigned ValueW       = 32;
  localparam int unsigned StatusW      = 3;

  typedef enum logic [1:0] {
    ACT_LOAD  = 2'd0,
    ACT_MERGE = 2'd1,
    ACT_READ  = 2'd2,
    ACT_CLEAR = 2'd3
  } action_e;

  typedef enum logic [StatusW-1:0] {
    ST_STORED = 3'd0,
    ST_DUP    = 3'd1,
    ST_FULL   = 3'd2,
    ST_READ   = 3'd3,
    ST_EMPTY  = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    OP_HOLD   = 3'd0,
    OP_APPEND = 3'd1,
    OP_INSERT = 3'd2,
    OP_ROTATE = 3'd3,
    OP_CLEAR  = 3'd4
  } cell_op_e;

  typedef struct packed {
    cell_op_e                  op;
    logic signed [ValueW-1:0]  value;
  } cell_ctrl_t;

endpackage

// ===== hw/rtl/ssu_cell.sv =====
// One table slot of the insertion chain: holds a value and its valid flag.
module ssu_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ssu_pkg::cell_ctrl_t ctrl_i,
  input  logic               prev_valid_i,
  input  logic signed [31:0] prev_value_i,
  input  logic               prev_before_i,
  input  logic               next_valid_i,
  input  logic signed [31:0] next_value_i,
  input  logic signed [31:0] head_value_i,
  output logic               valid_o,
  output logic signed [31:0] value_o,
  output logic               before_o,
  output logic               dup_o
);
  import ssu_pkg::*;

  logic               valid_q, valid_d;
  logic signed [31:0] value_q, value_d;
  logic               hit;
  logic               slot_free;

  // A hit marks an entry larger than the incoming value; the first hit in
  // the chain is where the new value goes, and every cell after it shifts.
  assign hit       = valid_q && (ctrl_i.value < value_q);
  assign slot_free = !valid_q && prev_valid_i;
  assign before_o  = prev_before_i || hit;
  assign dup_o     = valid_q && (ctrl_i.value == value_q);
  assign valid_o   = valid_q;
  assign value_o   = value_q;

  always_comb begin
    valid_d = valid_q;
    value_d = value_q;
    case (ctrl_i.op)
      OP_APPEND: begin
        if (slot_free) begin
          valid_d = 1'b1;
          value_d = ctrl_i.value;
        end
      end
      OP_INSERT: begin
        if (prev_before_i) begin
          valid_d = prev_valid_i;
          value_d = prev_value_i;
        end else if (hit || slot_free) begin
          valid_d = 1'b1;
          value_d = ctrl_i.value;
        end
      end
      OP_ROTATE: begin
        // The valid entries form a ring that wraps back through the head.
        if (valid_q) begin
          value_d = next_valid_i ? next_value_i : head_value_i;
        end
      end
      OP_CLEAR: begin
        valid_d = 1'b0;
      end
      default: begin
        valid_d = valid_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

endmodule

// ===== hw/rtl/sorted_set_union_insert_top.sv =====
// Top level of the sorted set union table: cell chain, control and result register.
//
// The table is a chain of DEPTH cells, one entry each. A merge keeps the
// entries in order, while a load appends its value after the last valid
// entry. On a merge word every cell compares the incoming value with its
// own entry in parallel, and the cells from the first larger entry onward
// shift one place while the new value drops into the gap. A read word puts
// the control into its read state, where the valid entries rotate through
// the head cell and leave by the result register one per cycle while the
// output is not stalled; a read of an empty table gives one empty result.
// Results wait in a single output register, and the next input word is accepted
// in the same cycle that a waiting result is taken. Clear produces no result.
module sorted_set_union_insert_top #(
  parameter int unsigned DEPTH = ssu_pkg::DefaultDepth
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [1:0]              action_i,
  input  logic signed [31:0]      value_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [2:0]              status_o,
  output logic signed [31:0]      entry_value_o,
  output logic                    last_o
);
  import ssu_pkg::*;

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_READ = 2'b10
  } state_e;

  state_e              state_q, state_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [CntW-1:0]     rd_q, rd_d;
  logic                out_vld_q, out_vld_d;
  status_e             out_status_q, out_status_d;
  logic signed [31:0]  out_value_q, out_value_d;
  logic                out_last_q, out_last_d;

  cell_ctrl_t          ctrl;
  logic                out_free;
  logic                in_acc;
  logic                full;
  logic                dup;
  logic                rd_last;
  action_e             action;

  logic [DEPTH-1:0]    cell_valid;
  logic signed [31:0]  cell_value [DEPTH];
  logic [DEPTH:0]      before_chain;
  logic [DEPTH-1:0]    dup_vec;

  assign action     = action_e'(action_i);
  assign out_free   = !out_vld_q || !out_stall_i;
  assign in_stall_o = !((state_q == S_IDLE) && out_free);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign full       = cell_valid[DEPTH-1];
  assign dup        = |dup_vec;
  assign rd_last    = (rd_q == (cnt_q - CntW'(1)));
  assign before_chain[0] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic               prev_valid;
    logic signed [31:0] prev_value;
    logic               next_valid;
    logic signed [31:0] next_value;

    if (i == 0) begin : g_head
      assign prev_valid = 1'b1;
      assign prev_value = 32'sd0;
    end else begin : g_body
      assign prev_valid = cell_valid[i-1];
      assign prev_value = cell_value[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign next_valid = 1'b0;
      assign next_value = 32'sd0;
    end else begin : g_mid
      assign next_valid = cell_valid[i+1];
      assign next_value = cell_value[i+1];
    end

    ssu_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl),
      .prev_valid_i  (prev_valid),
      .prev_value_i  (prev_value),
      .prev_before_i (before_chain[i]),
      .next_valid_i  (next_valid),
      .next_value_i  (next_value),
      .head_value_i  (cell_value[0]),
      .valid_o       (cell_valid[i]),
      .value_o       (cell_value[i]),
      .before_o      (before_chain[i+1]),
      .dup_o         (dup_vec[i])
    );
  end

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    rd_d         = rd_q;
    ctrl.op      = OP_HOLD;
    ctrl.value   = value_i;
    out_vld_d    = out_vld_q && out_stall_i;
    out_status_d = out_status_q;
    out_value_d  = out_value_q;
    out_last_d   = out_last_q;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          case (action)
            ACT_LOAD: begin
              out_vld_d   = 1'b1;
              out_value_d = 32'sd0;
              out_last_d  = 1'b1;
              if (full) begin
                out_status_d = ST_FULL;
              end else begin
                out_status_d = ST_STORED;
                ctrl.op      = OP_APPEND;
                cnt_d        = cnt_q + CntW'(1);
              end
            end
            ACT_MERGE: begin
              out_vld_d   = 1'b1;
              out_value_d = 32'sd0;
              out_last_d  = 1'b1;
              if (dup) begin
                out_status_d = ST_DUP;
              end else if (full) begin
                out_status_d = ST_FULL;
              end else begin
                out_status_d = ST_STORED;
                ctrl.op      = OP_INSERT;
                cnt_d        = cnt_q + CntW'(1);
              end
            end
            ACT_READ: begin
              if (cnt_q == '0) begin
                out_vld_d    = 1'b1;
                out_status_d = ST_EMPTY;
                out_value_d  = 32'sd0;
                out_last_d   = 1'b1;
              end else begin
                rd_d    = '0;
                state_d = S_READ;
              end
            end
            ACT_CLEAR: begin
              ctrl.op = OP_CLEAR;
              cnt_d   = '0;
            end
            default: begin
              ctrl.op = OP_HOLD;
            end
          endcase
        end
      end
      S_READ: begin
        // Emit the head entry and rotate the ring; after the last entry the
        // table is back in its original order.
        if (out_free) begin
          out_vld_d    = 1'b1;
          out_status_d = ST_READ;
          out_value_d  = cell_value[0];
          out_last_d   = rd_last;
          ctrl.op      = OP_ROTATE;
          rd_d         = rd_q + CntW'(1);
          if (rd_last) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      rd_q      <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      rd_q      <= rd_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_status_q <= out_status_d;
    out_value_q  <= out_value_d;
    out_last_q   <= out_last_d;
  end

  assign out_valid_o   = out_vld_q;
  assign status_o      = out_status_q;
  assign entry_value_o = out_value_q;
  assign last_o        = out_last_q;

endmodule
